// ===== src/first_match_rule_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the first-match rule classifier.
// Each macro expands to a labelled concurrent assertion, or to nothing.
// ----------------------------------------------------------------------------
`ifndef FIRST_MATCH_RULE_CLASSIFIER_MACROS_SVH
`define FIRST_MATCH_RULE_CLASSIFIER_MACROS_SVH
`ifndef ASSERT_OFF
`define FMRC_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define FMRC_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define FMRC_ASSERT_IMPL(label, clk, rst, prop)
`define FMRC_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== src/fmrc_pkg.sv =====
// ----------------------------------------------------------------------------
// First-match rule classifier package
// Types, request codes and sizing constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none
package fmrc_pkg;
  localparam int MAX_RULES   = 16;
  localparam int MAX_CLAUSES = 8;
  localparam int MAX_SLOTS   = 63;
  localparam int RULE_W      = 4;
  localparam int CL_W        = 3;
  localparam int ADDR_W      = RULE_W + CL_W;
  localparam int ENTRY_W     = 21;
  localparam int TALLY_W     = 12;

  localparam logic [1:0] REQ_WRITE    = 2'd0;
  localparam logic [1:0] REQ_COUNT    = 2'd1;
  localparam logic [1:0] REQ_CLASSIFY = 2'd2;
  localparam logic [1:0] REQ_REACH    = 2'd3;

  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_NE = 3'd1;
  localparam logic [2:0] CMP_GT = 3'd2;
  localparam logic [2:0] CMP_GE = 3'd3;
  localparam logic [2:0] CMP_LT = 3'd4;
  localparam logic [2:0] CMP_LE = 3'd5;

  localparam logic [1:0] FLD_TOTAL = 2'd0;
  localparam logic [1:0] FLD_HUMAN = 2'd1;

  localparam logic CFG_MAX_SLOT   = 1'b0;
  localparam logic CFG_RULE_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         rule_index;
    logic [2:0]         clause_index;
    logic [1:0]         clause_field;
    logic [2:0]         comparator;
    logic signed [15:0] compare_value;
    logic [3:0]         clause_count;
    logic [5:0]         total_count;
    logic [5:0]         human_count;
    logic [5:0]         ai_count;
    logic               target_is_default;
  } fmrc_req_t;

  typedef struct packed {
    logic       match_found;
    logic [3:0] match_index;
    logic       reachable;
    logic       shadow_found;
    logic [3:0] shadow_index;
  } fmrc_rsp_t;

  typedef struct packed {
    logic       wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic       rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic       clear_tally;
    logic       tally_en;
    logic [RULE_W-1:0] tally_idx;
    logic [RULE_W-1:0] scan_idx;
  } fmrc_cmd_t;

  typedef struct packed {
    logic              clause_pass;
    logic [TALLY_W-1:0] tally_val;
  } fmrc_sts_t;
endpackage
`default_nettype wire

// ===== src/fmrc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module fmrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== src/fmrc_datapath.sv =====
// ----------------------------------------------------------------------------
// Classifier datapath
// Clause store, clause evaluation against the current triple, win tallies.
// ----------------------------------------------------------------------------
`default_nettype none
module fmrc_datapath (
  input  wire logic               clk,
  input  wire fmrc_pkg::fmrc_cmd_t cmd,
  input  wire logic [20:0]        wr_entry,
  input  wire logic [5:0]         t,
  input  wire logic [5:0]         h,
  input  wire logic [5:0]         a,
  output fmrc_pkg::fmrc_sts_t     sts
);
  import fmrc_pkg::*;

  logic [ENTRY_W-1:0] entry;
  logic [1:0]         fld;
  logic [2:0]         cmp;
  logic signed [16:0] val;
  logic signed [16:0] x;
  logic [TALLY_W-1:0] tally [MAX_RULES];

  fmrc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RULES * MAX_CLAUSES)) u_store (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(cmd.wr_addr),
    .wr_data(wr_entry),
    .rd_en  (cmd.rd_en),
    .rd_addr(cmd.rd_addr),
    .rd_data(entry)
  );

  always_comb begin
    fld = entry[1:0];
    cmp = entry[4:2];
    val = {entry[20], entry[20:5]};
    if (fld == FLD_TOTAL) begin
      x = {11'd0, t};
    end else if (fld == FLD_HUMAN) begin
      x = {11'd0, h};
    end else begin
      x = {11'd0, a};
    end
    case (cmp)
      CMP_EQ:  sts.clause_pass = (x == val);
      CMP_NE:  sts.clause_pass = (x != val);
      CMP_GT:  sts.clause_pass = (x > val);
      CMP_GE:  sts.clause_pass = (x >= val);
      CMP_LT:  sts.clause_pass = (x < val);
      CMP_LE:  sts.clause_pass = (x <= val);
      default: sts.clause_pass = 1'b0;
    endcase
    sts.tally_val = tally[cmd.scan_idx];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RULES; i++) begin
      if (cmd.clear_tally) begin
        tally[i] <= '0;
      end else if (cmd.tally_en && cmd.tally_idx == RULE_W'(i)) begin
        tally[i] <= tally[i] + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/fmrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Classifier controller
// Sequences rules and clauses, the reachability sweep and the tally scan.
// ----------------------------------------------------------------------------
`default_nettype none
module fmrc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire fmrc_pkg::fmrc_req_t req,
  output logic                     in_stall,
  input  wire logic [5:0]          max_slot_count,
  input  wire logic [4:0]          rule_count,
  output fmrc_pkg::fmrc_cmd_t      cmd,
  input  wire fmrc_pkg::fmrc_sts_t sts,
  output logic [5:0]               t,
  output logic [5:0]               h,
  output logic [5:0]               a,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output fmrc_pkg::fmrc_rsp_t      rsp
);
  import fmrc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RULE, S_READ, S_CHECK, S_NEXT, S_SCAN, S_DONE
  } state_t;

  state_t state;
  fmrc_req_t cur;
  logic [3:0] cnt [MAX_RULES];
  logic [RULE_W-1:0] r;
  logic [CL_W:0] c;
  logic [RULE_W:0] nrules;
  logic [5:0] lim;
  logic [RULE_W:0] winner;
  logic hit;
  logic [RULE_W:0] best;
  logic [TALLY_W-1:0] best_val;
  logic [RULE_W:0] target;
  logic tvalid;
  logic [3:0] ncl;

  assign nrules = (rule_count > 5'(MAX_RULES)) ? 5'(MAX_RULES) : rule_count;
  assign lim    = max_slot_count;
  assign ncl    = cnt[r];
  assign target = cur.target_is_default ? 5'(MAX_RULES) : {1'b0, cur.rule_index};
  assign tvalid = cur.target_is_default || ({1'b0, cur.rule_index} < nrules);
  assign in_stall = rst || (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    cmd = '0;
    cmd.wr_en   = (state == S_IDLE) && in_valid && !in_stall && req.req_type == REQ_WRITE;
    cmd.wr_addr = {req.rule_index, req.clause_index};
    cmd.rd_en   = (state == S_READ);
    cmd.rd_addr = {r, c[CL_W-1:0]};
    cmd.clear_tally = (state == S_IDLE) && in_valid && !in_stall;
    cmd.scan_idx = r;
    cmd.tally_en = 1'b0;
    cmd.tally_idx = winner[RULE_W-1:0];
    if (state == S_NEXT && cur.req_type == REQ_REACH && !winner[RULE_W] &&
        winner != target) begin
      cmd.tally_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_RULES; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cur <= req;
            rsp <= '0;
            t <= '0;
            h <= '0;
            a <= '0;
            hit <= 1'b0;
            unique case (req.req_type)
              REQ_WRITE: begin
                out_valid <= 1'b1;
              end
              REQ_COUNT: begin
                cnt[req.rule_index] <= (req.clause_count > 4'(MAX_CLAUSES)) ?
                                       4'(MAX_CLAUSES) : req.clause_count;
                out_valid <= 1'b1;
              end
              REQ_CLASSIFY: begin
                t <= req.total_count;
                h <= req.human_count;
                a <= req.ai_count;
                r <= '0;
                c <= '0;
                state <= S_RULE;
              end
              default: begin
                r <= '0;
                c <= '0;
                state <= S_RULE;
              end
            endcase
          end
        end
        S_RULE: begin
          if ({1'b0, r} >= nrules) begin
            winner <= 5'(MAX_RULES);
            state <= S_NEXT;
          end else if ({1'b0, c} >= {1'b0, ncl}) begin
            winner <= {1'b0, r};
            state <= S_NEXT;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (sts.clause_pass) begin
            c <= c + 1'b1;
          end else begin
            c <= '0;
            if (r == RULE_W'(MAX_RULES - 1)) begin
              winner <= 5'(MAX_RULES);
              state <= S_NEXT;
            end else begin
              r <= r + 1'b1;
            end
          end
          if (!(!sts.clause_pass && r == RULE_W'(MAX_RULES - 1))) begin
            state <= S_RULE;
          end
        end
        S_NEXT: begin
          r <= '0;
          c <= '0;
          if (cur.req_type == REQ_CLASSIFY) begin
            rsp.match_found <= !winner[RULE_W];
            rsp.match_index <= winner[RULE_W] ? 4'd0 : winner[RULE_W-1:0];
            state <= S_DONE;
          end else begin
            if (tvalid && winner == target) begin
              hit <= 1'b1;
            end
            if (h == t) begin
              if (t == lim) begin
                best <= 5'(MAX_RULES);
                best_val <= '0;
                state <= S_SCAN;
              end else begin
                t <= t + 1'b1;
                h <= '0;
                a <= t + 1'b1;
                state <= S_RULE;
              end
            end else begin
              h <= h + 1'b1;
              a <= a - 1'b1;
              state <= S_RULE;
            end
          end
        end
        S_SCAN: begin
          if (sts.tally_val != '0 && (best[RULE_W] || sts.tally_val > best_val)) begin
            best <= {1'b0, r};
            best_val <= sts.tally_val;
          end
          if (r == RULE_W'(MAX_RULES - 1)) begin
            state <= S_DONE;
          end else begin
            r <= r + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            if (cur.req_type == REQ_REACH) begin
              rsp.reachable <= hit;
              rsp.shadow_found <= !hit && !best[RULE_W];
              rsp.shadow_index <= (!hit && !best[RULE_W]) ? best[RULE_W-1:0] : 4'd0;
            end
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/first_match_rule_classifier.sv =====
// Write and count requests are answered from the idle state; classify reads and checks
// each clause of each rule in turn; reachability checks run that walk for every
// triple of the sweep (up to 2080 triples) followed by a scan of all 16 win tallies.
// One request is in work at a time; the clause RAM's single read port sets the pace.
// Synchronous reset clears clause counts, registers and control; clause data is kept.
// ----------------------------------------------------------------------------
// First-match rule classifier
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_match_rule_classifier_macros.svh"
module first_match_rule_classifier (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire fmrc_pkg::fmrc_req_t in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output fmrc_pkg::fmrc_rsp_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [5:0]          cfg_data
);
  import fmrc_pkg::*;

  logic [5:0] max_slot_count;
  logic [4:0] rule_count;
  fmrc_cmd_t cmd;
  fmrc_sts_t sts;
  logic [5:0] t, h, a;
  logic [20:0] wr_entry;

  assign cfg_ready = !rst;
  assign wr_entry = {in_data.compare_value, in_data.comparator, in_data.clause_field};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_slot_count <= '0;
      rule_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_SLOT:   max_slot_count <= cfg_data;
        CFG_RULE_COUNT: rule_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  fmrc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .req(in_data), .in_stall(in_stall),
    .max_slot_count(max_slot_count), .rule_count(rule_count), .cmd(cmd), .sts(sts),
    .t(t), .h(h), .a(a), .out_valid(out_valid), .out_stall(out_stall), .rsp(out_data)
  );

  fmrc_datapath u_dp (
    .clk(clk), .cmd(cmd), .wr_entry(wr_entry), .t(t), .h(h), .a(a), .sts(sts)
  );

  `FMRC_ASSERT_IMPL(a_busy_stalls, clk, rst, (out_valid && out_stall) |-> in_stall)
  `FMRC_ASSERT_IMPL(a_found_idx, clk, rst,
                    (out_valid && !out_data.match_found) |-> (out_data.match_index == 4'd0))
  `FMRC_ASSERT_IMPL(a_reach_excl, clk, rst, out_valid |-> !(out_data.reachable && out_data.shadow_found))
endmodule
`default_nettype wire
